// ===== hw/rtl/soc_pkg.sv =====
// Shared types and codes for the substring occurrence counter.
// No dependencies; imported by the match logic, the top level and the checker.
package soc_pkg;

    typedef logic [7:0] byte_t;

    // Item kinds carried on s_tuser.
    localparam logic [1:0] ACT_CHAR = 2'd0;
    localparam logic [1:0] ACT_EOL  = 2'd1;
    localparam logic [1:0] ACT_EOF  = 2'd2;

    // Register indexes, taken from paddr[4:3].
    localparam logic [1:0] REG_LENGTH   = 2'd0;
    localparam logic [1:0] REG_PAT_LOW  = 2'd1;
    localparam logic [1:0] REG_PAT_HIGH = 2'd2;

    localparam int ACTION_W   = 2;
    localparam int LENGTH_W   = 5;
    localparam int COUNT_W    = 32;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;

    localparam logic [LENGTH_W-1:0] LENGTH_RESET = 5'd1;

endpackage

// ===== hw/rtl/soc_match.sv =====
// Parallel pattern compare over the current search window.
// Depends on soc_pkg for the byte type.
module soc_match #(
    parameter int MAX_PATTERN = 16,
    parameter int LEN_W       = 5
) (
    input  soc_pkg::byte_t [MAX_PATTERN-1:0] window,
    input  soc_pkg::byte_t [MAX_PATTERN-1:0] pattern,
    input  logic [LEN_W-1:0]                 eff_len,
    input  logic [LEN_W-1:0]                 have,
    output logic                             hit
);
    import soc_pkg::*;

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [MAX_PATTERN-1:0] lane_ok;

    // Window slot k (slot 0 is the newest character) must equal pattern
    // byte len-1-k; slots at or beyond the pattern length do not take part.
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_lane
        logic [LEN_W-1:0] pos;
        assign pos = eff_len - LEN_W'(k + 1);
        assign lane_ok[k] = (LEN_W'(k) >= eff_len) ||
                            (window[k] == pattern[pos[IDX_W-1:0]]);
    end

    assign hit = (&lane_ok) && (have >= eff_len);

endmodule

// ===== hw/rtl/substring_occurrence_counter.sv =====
// Top level of the substring occurrence counter: stream ports, register port,
// input and result registers. Depends on soc_pkg and soc_match.
//
// The block counts non-overlapping occurrences of a pattern of 1 to 16 bytes in
// a text stream carried one item per request on the s_ channel. Each request
// is a character, an end of line or an end of file, and produces exactly one
// result on the m_ channel: whether this character completes a counted match,
// the running count for the file, and a final flag on the end-of-file result.
// A match never spans an end of line, and after a match the search restarts
// just past it, so overlapping occurrences are not counted. The count
// saturates at 0xFFFFFFFF and is cleared after the end-of-file result. The
// block takes one request per clock cycle for as long as results are taken:
// a request is latched into an input register, all pattern positions are
// compared in parallel while it is held there, and the result is written to
// the output register once that register is free or being emptied. The
// user must write the pattern and its length through the register port only
// while the stream is idle; the block itself does not enforce this. Unused
// action code 3 behaves like an end of line.
module substring_occurrence_counter #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [soc_pkg::IN_DATA_W-1:0]     s_tdata,   // [7:0] char_byte
    input  logic [soc_pkg::ACTION_W-1:0]      s_tuser,   // [1:0] action
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [soc_pkg::OUT_DATA_W-1:0]    m_tdata,   // [0] match_found,
                                                         // [32:1] total_count,
                                                         // [39:33] zero
    output logic                              m_tuser,   // [0] is_final
    // Register port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [soc_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [soc_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [soc_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import soc_pkg::*;

    localparam int HIST_D = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [LENGTH_W-1:0] pattern_length_reg;
    logic [63:0]         pattern_low_reg;
    logic [63:0]         pattern_high_reg;
    logic                cfg_write;
    logic [1:0]          cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_length_reg <= LENGTH_RESET;
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_LENGTH:   pattern_length_reg <= pwdata[LENGTH_W-1:0];
                REG_PAT_LOW:  pattern_low_reg    <= pwdata;
                REG_PAT_HIGH: pattern_high_reg   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            REG_LENGTH:   prdata = {{(CFG_DATA_W-LENGTH_W){1'b0}}, pattern_length_reg};
            REG_PAT_LOW:  prdata = pattern_low_reg;
            REG_PAT_HIGH: prdata = pattern_high_reg;
            default:      prdata = '0;
        endcase
    end

    // Pattern bytes as an array; bytes past the sixteenth read as zero.
    byte_t [MAX_PATTERN-1:0] pattern;
    for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_pat
        if (i < 8) begin : g_low
            assign pattern[i] = pattern_low_reg[8*i +: 8];
        end else if (i < 16) begin : g_high
            assign pattern[i] = pattern_high_reg[8*(i-8) +: 8];
        end else begin : g_zero
            assign pattern[i] = '0;
        end
    end

    // A length of zero acts as one, and anything above the maximum as the maximum.
    logic [LEN_W-1:0] eff_len;
    always_comb begin
        if (pattern_length_reg == '0) begin
            eff_len = LEN_W'(1);
        end else if (int'(pattern_length_reg) > MAX_PATTERN) begin
            eff_len = LEN_W'(MAX_PATTERN);
        end else begin
            eff_len = LEN_W'(pattern_length_reg);
        end
    end

    // ------------------------------------------------------------------
    // Input register. It moves on whenever the output register is free or
    // being emptied, so one request per cycle flows through.
    // ------------------------------------------------------------------
    logic                in_valid_reg;
    logic [ACTION_W-1:0] in_action_reg;
    byte_t               in_char_reg;
    logic                m_tvalid_reg;
    logic                advance;
    logic                step;

    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step     = in_valid_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_action_reg <= s_tuser;
            in_char_reg   <= s_tdata[7:0];
        end
    end

    // ------------------------------------------------------------------
    // Search state: recent characters (newest in slot 0), characters since the
    // search last restarted, and the file count.
    // ------------------------------------------------------------------
    byte_t [HIST_D-1:0]  hist_reg;
    byte_t [HIST_D-1:0]  hist_next;
    logic [LEN_W-1:0]    since_reg;
    logic [LEN_W-1:0]    since_next;
    logic [COUNT_W-1:0]  total_reg;
    logic [COUNT_W-1:0]  total_next;
    logic [LEN_W-1:0]    have;
    logic [LEN_W:0]      have_wide;
    byte_t [MAX_PATTERN-1:0] window;
    logic                hit;
    logic                found;
    logic                is_final;
    logic [COUNT_W-1:0]  reported;

    assign have_wide = {1'b0, since_reg} + (LEN_W+1)'(1);
    assign have = (int'(have_wide) > MAX_PATTERN) ? LEN_W'(MAX_PATTERN)
                                                  : have_wide[LEN_W-1:0];

    always_comb begin
        window[0] = in_char_reg;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            window[k] = hist_reg[k-1];
        end
    end

    soc_match #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LEN_W)
    ) u_match (
        .window  (window),
        .pattern (pattern),
        .eff_len (eff_len),
        .have    (have),
        .hit     (hit)
    );

    always_comb begin
        hist_next[0] = in_char_reg;
        for (int k = 1; k < HIST_D; k++) begin
            hist_next[k] = hist_reg[k-1];
        end
    end

    always_comb begin
        found      = 1'b0;
        is_final   = 1'b0;
        since_next = '0;
        total_next = total_reg;
        reported   = total_reg;
        case (in_action_reg)
            ACT_CHAR: begin
                found = hit;
                if (hit) begin
                    // Saturating count; the search restarts past the match.
                    if (total_reg != '1) begin
                        total_next = total_reg + COUNT_W'(1);
                    end
                    since_next = '0;
                end else begin
                    since_next = have;
                end
                reported = total_next;
            end
            ACT_EOF: begin
                is_final   = 1'b1;
                total_next = '0;
            end
            default: begin
                // End of line, and the unused code, only restart the search.
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg  <= '0;
            since_reg <= '0;
            total_reg <= '0;
        end else if (step) begin
            since_reg <= since_next;
            total_reg <= total_next;
            if (in_action_reg == ACT_CHAR) begin
                hist_reg <= hist_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    logic               m_found_reg;
    logic [COUNT_W-1:0] m_count_reg;
    logic               m_final_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_found_reg <= found;
            m_count_reg <= reported;
            m_final_reg <= is_final;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W-COUNT_W-1){1'b0}}, m_count_reg, m_found_reg};
    assign m_tuser  = m_final_reg;

endmodule

// ===== hw/rtl/soc_checker.sv =====
// Port-level checker for the substring occurrence counter, bound to the top.
// Depends on soc_pkg and substring_occurrence_counter.
module soc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [soc_pkg::OUT_DATA_W-1:0]   m_tdata,
    input logic                             m_tuser
);
    import soc_pkg::*;

    logic               prev_valid_reg;
    logic               prev_final_reg;
    logic [COUNT_W-1:0] prev_count_reg;
    logic               out_take;

    assign out_take = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_valid_reg <= 1'b0;
        end else if (out_take) begin
            prev_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_take) begin
            prev_final_reg <= m_tuser;
            prev_count_reg <= m_tdata[COUNT_W:1];
        end
    end

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // With no result waiting, the block must take a new request.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output");

    // The end-of-file result never reports a match, and a match has a count.
    a_final_no_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser || m_tdata[0]) |-> !(m_tuser && m_tdata[0]) &&
        (m_tuser || m_tdata[COUNT_W:1] != '0))
        else $error("inconsistent match flag");

    // Within a file the count never falls; after an end of file it restarts.
    a_count_order: assert property (@(posedge aclk) disable iff (!aresetn)
        out_take && prev_valid_reg |->
        (prev_final_reg ? (m_tdata[COUNT_W:1] <= COUNT_W'(1))
                        : (m_tdata[COUNT_W:1] >= prev_count_reg)))
        else $error("count out of order");

endmodule

bind substring_occurrence_counter soc_checker u_soc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/sv/substring_occurrence_counter_tb.sv =====
// Self-checking testbench for the substring occurrence counter.
// Depends on soc_pkg and the substring_occurrence_counter top level only.
`timescale 1ns / 1ps

module substring_occurrence_counter_tb;

    import soc_pkg::*;

    // The spare action code has no name in the package; the block treats it
    // like an end of line.
    localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

    localparam int unsigned PATTERN_MAX   = 16;
    localparam int unsigned HISTORY_DEPTH = PATTERN_MAX - 1;
    // Results pass through an input and an output register, so these idle
    // stretches are plenty before touching a register or ending the run.
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned END_SETTLE    = 8;
    // Longest quiet stretch of a correct run is a long sender gap plus a long
    // receiver stall.
    localparam int unsigned STALL_LIMIT   = 4000;
    localparam int unsigned REPORT_CAP    = 200;
    localparam int unsigned PHASE_ITEMS   = 170;

    typedef enum logic [1:0] {
        JOB_REQUEST,
        JOB_REG_WRITE,
        JOB_DRAIN
    } job_kind_t;

    // One entry of the stimulus list: a stream request, a register write, or
    // a pause that holds the sender until every result has come back.
    typedef struct {
        job_kind_t             kind;
        logic [ACTION_W-1:0]   action;
        byte_t                 char_byte;
        logic [1:0]            reg_idx;
        logic [CFG_DATA_W-1:0] value;
    } job_t;

    // What one result should carry.
    typedef struct packed {
        logic               match_found;
        logic [COUNT_W-1:0] total_count;
        logic               is_final;
    } tally_t;

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata  = '0;     // [7:0] char_byte
    logic [ACTION_W-1:0]     s_tuser  = '0;     // [1:0] action
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_tdata;           // [0] match_found, [32:1] total_count
    logic                    m_tuser;           // [0] is_final
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b1;
    logic [CFG_ADDR_W-1:0]   paddr    = '0;
    logic [CFG_DATA_W-1:0]   pwdata   = '0;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;

    substring_occurrence_counter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 aclk = ~aclk;

    // Stimulus waiting to be driven, and results still owed by the block.
    job_t   pending_requests [$];
    tally_t expected_tallies [$];

    // Our own copy of the block's registers and search state.
    logic [LENGTH_W-1:0]   cfg_length = LENGTH_RESET;
    logic [CFG_DATA_W-1:0] cfg_pat_low  = '0;
    logic [CFG_DATA_W-1:0] cfg_pat_high = '0;
    byte_t                 recent [HISTORY_DEPTH];
    int unsigned           run_chars  = 0;
    logic [COUNT_W-1:0]    file_total = '0;

    int unsigned mismatch_count = 0;
    int unsigned result_seq     = 0;
    int unsigned quiet_cycles   = 0;
    // Set by the monitor when the request on the bus was taken; cleared by
    // the driver at its falling edge.
    bit          req_accepted   = 1'b0;
    int unsigned settle_count   = 0;
    int unsigned send_gap       = 0;
    int unsigned send_calm      = 0;
    int unsigned recv_stall     = 0;
    int unsigned recv_calm      = 0;

    initial begin
        for (int i = 0; i < HISTORY_DEPTH; i++) recent[i] = 8'h00;
    end

    task automatic flag_mismatch(input string what);
        if (mismatch_count < REPORT_CAP) $display("%0t ERROR %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic byte_t pattern_at(input int unsigned idx);
        if (idx < 8) return cfg_pat_low[8*idx +: 8];
        return cfg_pat_high[8*(idx-8) +: 8];
    endfunction

    // Advances the search state by one request and returns what the block
    // has to report for it. The last pattern byte is compared with the new
    // character and the earlier ones with the history, newest first.
    function automatic tally_t scan_request(input logic [ACTION_W-1:0] action, input byte_t ch);
        tally_t      res;
        int unsigned len;
        int unsigned have;
        int unsigned k;
        bit          hit;
        res = '0;
        if (action == ACT_CHAR) begin
            len = cfg_length;
            if (len == 0) len = 1;
            if (len > PATTERN_MAX) len = PATTERN_MAX;
            have = run_chars + 1;
            if (have > PATTERN_MAX) have = PATTERN_MAX;
            hit = (have >= len) && (ch == pattern_at(len - 1));
            for (k = 0; k + 1 < len; k++) begin
                if (recent[k] != pattern_at(len - 2 - k)) hit = 1'b0;
            end
            for (k = HISTORY_DEPTH - 1; k > 0; k--) recent[k] = recent[k-1];
            recent[0] = ch;
            if (hit) begin
                if (file_total != '1) file_total++;
                run_chars = 0;
            end else begin
                run_chars = have;
            end
            res.match_found = hit;
            res.total_count = file_total;
        end else if (action == ACT_EOF) begin
            res.is_final    = 1'b1;
            res.total_count = file_total;
            file_total      = '0;
            run_chars       = 0;
        end else begin
            // End of line and the spare code both break any partial match.
            res.total_count = file_total;
            run_chars       = 0;
        end
        return res;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned draw_gap();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 55) return 0;
        if (pick < 85) return $urandom_range(3, 1);
        if (pick < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // Appends one entry at the tail of the stimulus list.
    task automatic queue_job(input job_t job);
        pending_requests.insert(pending_requests.size(), job);
    endtask

    task automatic push_char(input byte_t ch);
        queue_job('{JOB_REQUEST, ACT_CHAR, ch, 2'd0, '0});
    endtask

    // The character on control requests is meant to be ignored, so it is
    // random here.
    task automatic push_ctl(input logic [ACTION_W-1:0] action);
        queue_job('{JOB_REQUEST, action, byte_t'($urandom_range(255)), 2'd0, '0});
    endtask

    task automatic push_write(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
        queue_job('{JOB_REG_WRITE, ACT_CHAR, 8'h00, idx, value});
    endtask

    // Programs one pattern setting and then lays down a text for it. Most of
    // the text is built from whole copies of the pattern, broken prefixes of
    // it and runs of its own bytes, so that matches, near misses and
    // overlapping candidates are common; the rest is arbitrary bytes and
    // line and file ends. Halfway through, the sender waits for all results.
    task automatic fill_phase(input logic [LENGTH_W-1:0] len_code, input logic [127:0] pat,
                              input int unsigned n);
        int unsigned eff;
        int unsigned made;
        int unsigned run;
        int unsigned pick;
        int unsigned i;
        byte_t       alpha [4];
        bit          drained;
        eff = (len_code == 0) ? 1 : ((len_code > PATTERN_MAX) ? PATTERN_MAX : len_code);
        push_write(REG_LENGTH, CFG_DATA_W'(len_code));
        push_write(REG_PAT_LOW, pat[63:0]);
        push_write(REG_PAT_HIGH, pat[127:64]);
        for (i = 0; i < 3; i++) alpha[i] = pat[8*$urandom_range(eff - 1) +: 8];
        alpha[3] = byte_t'($urandom_range(255));
        made    = 0;
        drained = 1'b0;
        while (made < n) begin
            if (!drained && made >= n / 2) begin
                queue_job('{JOB_DRAIN, ACT_CHAR, 8'h00, 2'd0, '0});
                drained = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 35) begin
                for (i = 0; i < eff; i++) push_char(pat[8*i +: 8]);
                made += eff;
            end else if (pick < 45) begin
                run = $urandom_range(eff - 1);
                for (i = 0; i < run; i++) push_char(pat[8*i +: 8]);
                made += run;
            end else if (pick < 80) begin
                run = $urandom_range(6, 1);
                for (i = 0; i < run; i++) push_char(alpha[$urandom_range(3)]);
                made += run;
            end else if (pick < 88) begin
                push_char(byte_t'($urandom_range(255)));
                made++;
            end else if (pick < 95) begin
                push_ctl(ACT_EOL);
                made++;
            end else if (pick < 97) begin
                push_ctl(ACT_SPARE);
                made++;
            end else begin
                push_ctl(ACT_EOF);
                made++;
            end
        end
        // Close the file so every setting ends on a reported total.
        push_ctl(ACT_EOF);
    endtask

    // Driver: launches requests and register writes at the falling edge.
    // Each control signal is computed first and assigned once, so a valid
    // that stays high for back-to-back requests never dips within a step.
    always @(negedge aclk) begin
        logic nxt_valid;
        logic nxt_psel;
        logic nxt_penable;
        job_t job;
        if (aresetn) begin
            nxt_valid    = s_tvalid && !req_accepted;
            req_accepted = 1'b0;
            nxt_psel     = psel;
            nxt_penable  = penable;
            // The access phase completed at the last rising edge, since the
            // register port is always ready.
            if (psel && penable) begin
                nxt_psel    = 1'b0;
                nxt_penable = 1'b0;
            end else if (psel) begin
                nxt_penable = 1'b1;
            end
            if (!nxt_valid && expected_tallies.size() == 0) settle_count++;
            else settle_count = 0;
            if (!nxt_valid && !nxt_psel) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_requests.size() != 0) begin
                    job = pending_requests[0];
                    case (job.kind)
                        JOB_REQUEST: begin
                            nxt_valid = 1'b1;
                            s_tdata  <= job.char_byte;
                            s_tuser  <= job.action;
                            void'(pending_requests.pop_front());
                            if (send_calm > 0) begin
                                send_calm--;
                                send_gap = 0;
                            end else begin
                                send_gap = draw_gap();
                                if ($urandom_range(63) == 0) send_calm = $urandom_range(120, 30);
                            end
                        end
                        JOB_REG_WRITE: begin
                            // Registers change only with the stream at rest.
                            if (settle_count >= SETTLE_CYCLES) begin
                                nxt_psel    = 1'b1;
                                nxt_penable = 1'b0;
                                paddr      <= CFG_ADDR_W'({job.reg_idx, 3'b000});
                                pwdata     <= job.value;
                                void'(pending_requests.pop_front());
                            end
                        end
                        JOB_DRAIN: begin
                            if (expected_tallies.size() == 0) void'(pending_requests.pop_front());
                        end
                        default: void'(pending_requests.pop_front());
                    endcase
                end
            end
            s_tvalid <= nxt_valid;
            psel     <= nxt_psel;
            penable  <= nxt_penable;
        end
    end

    // Receiver: stalls of random length, with calm stretches of none.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (recv_calm > 0) begin
                    recv_calm--;
                end else if ($urandom_range(9) < 3) begin
                    recv_stall = draw_gap();
                    if ($urandom_range(63) == 0) recv_calm = $urandom_range(200, 40);
                end
            end
        end
    end

    // Monitor: at each rising edge predicts accepted requests, checks taken
    // results against the oldest expectation, tracks register writes and
    // counts cycles without any progress.
    always @(posedge aclk) begin
        tally_t want;
        bit     progress;
        if (aresetn) begin
            progress = 1'b0;
            if (s_tvalid && s_tready) begin
                expected_tallies.insert(expected_tallies.size(),
                                        scan_request(s_tuser, s_tdata));
                req_accepted = 1'b1;
                progress     = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                progress = 1'b1;
                if (expected_tallies.size() == 0) begin
                    flag_mismatch($sformatf("result %0d with nothing expected: tdata %h tuser %b",
                                            result_seq, m_tdata, m_tuser));
                end else begin
                    want = expected_tallies.pop_front();
                    if (m_tdata[0] !== want.match_found)
                        flag_mismatch($sformatf("result %0d match_found %b, expected %b",
                                                result_seq, m_tdata[0], want.match_found));
                    if (m_tdata[COUNT_W:1] !== want.total_count)
                        flag_mismatch($sformatf("result %0d total_count %0d, expected %0d",
                                                result_seq, m_tdata[COUNT_W:1],
                                                want.total_count));
                    if (m_tuser !== want.is_final)
                        flag_mismatch($sformatf("result %0d is_final %b, expected %b",
                                                result_seq, m_tuser, want.is_final));
                    if (m_tdata[OUT_DATA_W-1:COUNT_W+1] !== '0)
                        flag_mismatch($sformatf("result %0d padding bits %h not zero",
                                                result_seq, m_tdata[OUT_DATA_W-1:COUNT_W+1]));
                end
                result_seq++;
            end
            if (psel && penable && pwrite && pready) begin
                progress = 1'b1;
                case (paddr[CFG_ADDR_W-1:3])
                    REG_LENGTH:   cfg_length   = pwdata[LENGTH_W-1:0];
                    REG_PAT_LOW:  cfg_pat_low  = pwdata;
                    REG_PAT_HIGH: cfg_pat_high = pwdata;
                    default: ;
                endcase
            end
            quiet_cycles = progress ? 0 : quiet_cycles + 1;
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] word;
        logic [127:0]          pat;
        byte_t                 b0;
        byte_t                 b1;
        int unsigned           len;

        // Directed part, first with the reset setting: a one-byte pattern of
        // zero. Zero bytes match, an all-ones byte does not, line ends and
        // the spare code leave the count alone, and the end of file reports
        // the total and then clears it.
        push_char(8'h00);
        push_char(8'hFF);
        push_char(8'h00);
        push_ctl(ACT_EOL);
        push_ctl(ACT_SPARE);
        push_ctl(ACT_EOF);
        push_char(8'h00);
        push_ctl(ACT_EOF);

        // Pattern "aa" with junk in the unused bytes: a run of five counts
        // twice, not four times, and a match cannot straddle a line end.
        word       = {$urandom, $urandom};
        word[15:0] = 16'h6161;
        push_write(REG_LENGTH, CFG_DATA_W'(2));
        push_write(REG_PAT_LOW, word);
        push_write(REG_PAT_HIGH, {$urandom, $urandom});
        push_char(8'h61);
        push_char(8'h61);
        push_char(8'h61);
        push_char(8'h61);
        push_char(8'h61);
        push_ctl(ACT_EOL);
        push_char(8'h61);
        push_ctl(ACT_EOF);

        // Random part, one text per pattern setting.
        fill_phase(5'd16, {$urandom, $urandom, $urandom, $urandom}, PHASE_ITEMS);

        pat       = {$urandom, $urandom, $urandom, $urandom};
        b0        = byte_t'($urandom_range(255));
        pat[15:0] = {b0, b0};
        fill_phase(5'd2, pat, PHASE_ITEMS);

        // A zero length acts as one byte, anything past sixteen as sixteen.
        fill_phase(5'd0, {$urandom, $urandom, $urandom, $urandom}, PHASE_ITEMS);
        fill_phase(5'd31, {128{1'b1}}, PHASE_ITEMS);
        fill_phase(5'd16, '0, PHASE_ITEMS);

        // A periodic pattern gives plenty of overlapping candidates.
        b0  = byte_t'($urandom_range(255));
        b1  = byte_t'($urandom_range(255));
        len = $urandom_range(15, 3);
        for (int i = 0; i < 16; i++) pat[8*i +: 8] = (i % 2) ? b1 : b0;
        fill_phase(LENGTH_W'(len), pat, PHASE_ITEMS);

        // A length of nine uses both pattern registers.
        fill_phase(5'd9, {$urandom, $urandom, $urandom, $urandom}, PHASE_ITEMS);

        // Two-letter alphabet: partial matches break and restart often.
        b0  = byte_t'($urandom_range(255));
        b1  = b0 ^ 8'h01;
        len = $urandom_range(16, 1);
        for (int i = 0; i < 16; i++) pat[8*i +: 8] = $urandom_range(1) ? b1 : b0;
        fill_phase(LENGTH_W'(len), pat, PHASE_ITEMS);

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        while ((pending_requests.size() != 0 || s_tvalid || psel ||
                expected_tallies.size() != 0) && quiet_cycles < STALL_LIMIT)
            @(negedge aclk);
        // Give a stray extra result the chance to show up.
        repeat (END_SETTLE) @(negedge aclk);

        if (quiet_cycles >= STALL_LIMIT)
            flag_mismatch($sformatf("no progress for %0d cycles", quiet_cycles));
        if (expected_tallies.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", expected_tallies.size()));
        if (mismatch_count == 0) begin
            $display("substring_occurrence_counter_tb: clean");
        end else begin
            $display("substring_occurrence_counter_tb: errors");
        end
        $finish;
    end

endmodule
